### rtl/assert_macros.svh
// Assertion macros for the RTL of the palette quantizer; only the search engine (npc_back) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define NPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define NPC_NEVER(label, cond, msg) \
  `NPC_ASSERT(label, !(cond), msg)

`endif

### rtl/npc_pkg.sv
// Shared types, constants and helpers of the nearest palette color block.
`timescale 1ns / 1ps

package npc_pkg;

  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned SQ_W        = 16;
  localparam int unsigned DIST_W      = 18;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_MODE  = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // Larger than any sum of three squared channel differences.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  // Fixed answers that need no search.
  localparam logic [IDX_W-1:0] IDX_TRANSPARENT = 8'd0;
  localparam logic [IDX_W-1:0] IDX_EMPTY_RANGE = 8'd1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SEARCH,
    KIND_FIXED
  } npc_kind_e;

  // One classified item; idx is the entry for a load, the answer for a fixed item.
  typedef struct packed {
    npc_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } npc_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] limit;
    logic               alpha_mode;
  } npc_cfg_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/nearest_palette_color_top.sv
// Top level of the nearest palette color quantizer.
`timescale 1ns / 1ps

// Maps RGBA pixels to the index of the nearest entry of a palette held inside.
// Input stream (s_axis): tuser = action (0 loads palette entry entry_index with
// red/green/blue, 1 maps a pixel). Loads give no output transaction; a load past
// the palette is dropped. Pixels give one transaction on m_axis holding the index.
// Configuration channel (cfg_*): index 0 = color_count, index 1 = alpha_mode;
// write it only while no pixel is in flight. cfg_ready_o is always high.
// In alpha mode a pixel with alpha 0 answers index 0 without a search.
// Search: a pixel search walks the palette entries from the start entry up to
// the color count (clamped to the palette depth) - 1, one entry a cycle through
// the single palette read port; loads and fixed answers need no walk.
// A four-entry queue separates input acceptance from the search engine, and the
// result sits in an output register, so input keeps flowing while m_axis stalls
// until the queue fills. Reset clears control state and sets color_count to 256
// and alpha_mode to 0; palette entries are undefined until loaded.

module nearest_palette_color_top import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue, [39:32] alpha
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] color_index
  output logic [IDX_W-1:0]       m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [COUNT_W-1:0]     cfg_data_i
);

  logic [COUNT_W-1:0] color_count_q;
  logic               alpha_mode_q;
  npc_cfg_t           cfg;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  npc_item_t          fq_item, bq_item;

  assign cfg_ready_o = 1'b1;

  // Hold configuration; ignore writes to indexes outside the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= COUNT_RESET;
      alpha_mode_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COLOR_COUNT: color_count_q <= cfg_data_i;
        CFG_ALPHA_MODE:  alpha_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the color count to the palette depth.
  assign cfg.limit      = (color_count_q > COUNT_W'(PALETTE_ENTRIES)) ?
                          COUNT_W'(PALETTE_ENTRIES) : color_count_q;
  assign cfg.alpha_mode = alpha_mode_q;

  npc_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_i        (cfg),
    .q_valid_o    (fq_valid),
    .q_ready_i    (fq_ready),
    .q_item_o     (fq_item)
  );

  npc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fq_valid),
    .in_ready_o (fq_ready),
    .in_item_i  (fq_item),
    .out_valid_o(bq_valid),
    .out_ready_i(bq_ready),
    .out_item_o (bq_item)
  );

  npc_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (bq_valid),
    .q_ready_o    (bq_ready),
    .q_item_i     (bq_item),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

### rtl/npc_front.sv
// Input side: accepts stream transactions and classifies them for the search engine.
`timescale 1ns / 1ps

module npc_front import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  npc_cfg_t             cfg_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output npc_item_t            q_item_o
);

  logic [IDX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] alpha;
  logic              load_in_range;
  logic              range_empty;
  logic              keep;

  assign entry_index = s_axis_tdata[7:0];
  assign alpha       = s_axis_tdata[39:32];

  assign load_in_range = {1'b0, entry_index} < COUNT_W'(PALETTE_ENTRIES);
  assign range_empty   = {8'd0, cfg_i.alpha_mode} >= cfg_i.limit;

  always_comb begin
    q_item_o.idx   = entry_index;
    q_item_o.red   = s_axis_tdata[15:8];
    q_item_o.green = s_axis_tdata[23:16];
    q_item_o.blue  = s_axis_tdata[31:24];
    keep           = 1'b1;
    if (!s_axis_tuser) begin
      // drop loads aimed past the palette
      q_item_o.kind = KIND_LOAD;
      keep          = load_in_range;
    end else if (cfg_i.alpha_mode && (alpha == '0)) begin
      q_item_o.kind = KIND_FIXED;
      q_item_o.idx  = IDX_TRANSPARENT;
    end else if (range_empty) begin
      q_item_o.kind = KIND_FIXED;
      q_item_o.idx  = IDX_EMPTY_RANGE;
    end else begin
      q_item_o.kind = KIND_SEARCH;
    end
  end

  assign s_axis_tready = q_ready_i;
  assign q_valid_o     = s_axis_tvalid && keep;

endmodule

### rtl/npc_queue.sv
// Short FIFO of classified items between the front and the search engine.
`timescale 1ns / 1ps

module npc_queue import npc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  npc_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output npc_item_t out_item_o
);

  npc_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = count_q != QCNT_W'(QUEUE_DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = entries_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

### rtl/npc_back.sv
// Search engine: holds the palette, runs the distance scan and drives the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npc_back import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npc_cfg_t         cfg_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  npc_item_t        q_item_i,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [IDX_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [AW-1:0]            last_addr;
  logic [3*CHAN_W-1:0]      palette_mem [PALETTE_ENTRIES];
  logic [3*CHAN_W-1:0]      rd_data_q;
  logic                     s1_valid_q, s2_valid_q;
  logic [AW-1:0]            s1_idx_q, s2_idx_q;
  logic [SQ_W-1:0]          sq_r_q, sq_g_q, sq_b_q;
  logic [CHAN_W-1:0]        pix_r_q, pix_g_q, pix_b_q;
  logic [CHAN_W-1:0]        dr, dg, db;
  logic [DIST_W-1:0]        dist_sum;
  logic [DIST_W-1:0]        best_q;
  logic [AW-1:0]            best_idx_q;
  logic                     m_valid_q, m_valid_d;
  logic [IDX_W-1:0]         m_data_q;
  logic                     out_free, pipe_empty, q_pop, out_load;
  logic                     start_search, mem_we, best_hit;

  assign last_addr  = AW'(cfg_i.limit - COUNT_W'(1));
  assign out_free   = !m_valid_q || m_axis_tready;
  assign pipe_empty = !s1_valid_q && !s2_valid_q;

  assign q_ready_o    = (state_q == ST_IDLE) && ((q_item_i.kind != KIND_FIXED) || out_free);
  assign q_pop        = q_valid_i && q_ready_o;
  assign start_search = q_pop && (q_item_i.kind == KIND_SEARCH);
  assign mem_we       = q_pop && (q_item_i.kind == KIND_LOAD);
  assign out_load     = (q_pop && (q_item_i.kind == KIND_FIXED)) ||
                        ((state_q == ST_DRAIN) && pipe_empty && out_free);

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (start_search) begin
          state_d = ST_SCAN;
          addr_d  = AW'(cfg_i.alpha_mode);
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= state_q == ST_SCAN;
      s2_valid_q <= s1_valid_q;
      m_valid_q  <= m_valid_d;
    end
  end

  // Palette store: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[q_item_i.idx[AW-1:0]] <= {q_item_i.blue, q_item_i.green, q_item_i.red};
    end
    rd_data_q <= palette_mem[addr_q];
  end

  assign dr = abs_diff(pix_r_q, rd_data_q[7:0]);
  assign dg = abs_diff(pix_g_q, rd_data_q[15:8]);
  assign db = abs_diff(pix_b_q, rd_data_q[23:16]);

  assign dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign best_hit = s2_valid_q && (dist_sum < best_q);

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    s1_idx_q <= addr_q;
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_q   <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_q   <= SQ_W'(db) * SQ_W'(db);
    if (start_search) begin
      pix_r_q <= q_item_i.red;
      pix_g_q <= q_item_i.green;
      pix_b_q <= q_item_i.blue;
      best_q  <= DIST_INIT;
    end else if (best_hit) begin
      best_q     <= dist_sum;
      best_idx_q <= s2_idx_q;
    end
    if (out_load) begin
      m_data_q <= (state_q == ST_DRAIN) ? IDX_W'(best_idx_q) : q_item_i.idx;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `NPC_ASSERT(a_pop_only_idle, q_pop |-> (state_q == ST_IDLE), "queue popped while busy")
  `NPC_ASSERT(a_scan_bounded, (state_q == ST_SCAN) |-> (addr_q <= last_addr), "scan overran")
  `NPC_NEVER(a_no_overwrite, out_load && !out_free, "result register overwritten")
  `NPC_ASSERT(a_pipe_order, s2_valid_q |-> $past(s1_valid_q), "distance stage out of order")

endmodule

### dv/tb_nearest_palette_color_top.sv
// Self-checking testbench for the nearest palette color quantizer top level.
`timescale 1ns / 1ps

module tb_nearest_palette_color_top;
  import npc_pkg::*;

  localparam int unsigned ENTRIES       = 256;
  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned IDLE_PCT      = 32;
  // Loads can still sit in the input queue after the last result has left.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Longer than a full-palette search, so a stray result would show up.
  localparam int unsigned DRAIN_CYCLES  = 600;
  localparam int unsigned STALL_LIMIT   = 20000;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [IDX_W-1:0]       m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [COUNT_W-1:0]     cfg_data_i;

  // Testbench copy of the block state.
  rgb_t               palette_copy [ENTRIES];
  logic [COUNT_W-1:0] color_count_copy;
  logic               alpha_mode_copy;

  logic [IDX_W-1:0] pending_indices [$];

  int unsigned mismatch_count;
  int unsigned pixel_count;
  int unsigned load_count;
  int unsigned register_writes;
  int unsigned result_count;
  int unsigned quiet_cycles;
  bit          steady_flow;

  nearest_palette_color_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Search entries from the start entry up to the saturated color count;
  // the lowest index keeps a tie.
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] red,
                                                     input logic [CHAN_W-1:0] green,
                                                     input logic [CHAN_W-1:0] blue,
                                                     input logic [CHAN_W-1:0] alpha);
    int unsigned      limit;
    int unsigned      best;
    int unsigned      sq_dist;
    int               dr;
    int               dg;
    int               db;
    logic [IDX_W-1:0] pick;
    pick = IDX_EMPTY_RANGE;
    if (alpha_mode_copy && alpha == 0) begin
      return IDX_TRANSPARENT;
    end
    limit = (color_count_copy > ENTRIES) ? ENTRIES : color_count_copy;
    best  = 32'hffff_ffff;
    for (int unsigned j = alpha_mode_copy ? 1 : 0; j < limit; j++) begin
      dr      = int'(red)   - int'(palette_copy[j].red);
      dg      = int'(green) - int'(palette_copy[j].green);
      db      = int'(blue)  - int'(palette_copy[j].blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best) begin
        best = sq_dist;
        pick = j[IDX_W-1:0];
      end
    end
    return pick;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, want);
  endtask

  // Receiver: idle at random unless a steady stretch is running.
  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every result transaction with the oldest pending index.
  always @(posedge clk_i) begin
    logic [IDX_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_indices.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, -1);
      end else begin
        want = pending_indices.pop_front();
        if (m_axis_tdata !== want) begin
          report_mismatch("color_index", m_axis_tdata, want);
        end
      end
    end
  end

  // End the run when no channel moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("tb_nearest_palette_color_top failed");
        $finish;
      end
    end
  end

  // Send one item; update the palette copy or queue the expected index on acceptance.
  task automatic send_item(input logic action, input logic [IDX_W-1:0] entry,
                           input rgb_t color, input logic [CHAN_W-1:0] alpha);
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {alpha, color.blue, color.green, color.red, entry};
    do @(posedge clk_i); while (!s_axis_tready);
    if (action == ACT_LOAD) begin
      palette_copy[entry] = color;
      load_count++;
    end else begin
      pending_indices.push_back(nearest_entry(color.red, color.green, color.blue, alpha));
      pixel_count++;
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] entry, input rgb_t color);
    send_item(ACT_LOAD, entry, color, CHAN_W'($urandom_range(255)));
  endtask

  task automatic send_pixel(input rgb_t color, input logic [CHAN_W-1:0] alpha);
    send_item(ACT_PIXEL, IDX_W'($urandom_range(255)), color, alpha);
  endtask

  // Drop tvalid and hold until every pending index has come back.
  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_indices.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [COUNT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_COLOR_COUNT) begin
      color_count_copy = value;
    end else if (index == CFG_ALPHA_MODE) begin
      alpha_mode_copy = value[0];
    end
    register_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reconfigure only once the block has gone idle.
  task automatic configure(input logic [COUNT_W-1:0] count, input logic alpha_on);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(CFG_COLOR_COUNT, count);
    write_register(CFG_ALPHA_MODE, {{(COUNT_W-1){1'b0}}, alpha_on});
  endtask

  function automatic rgb_t random_color();
    return rgb_t'({CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                   CHAN_W'($urandom_range(255))});
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(8)) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[CHAN_W-1:0];
  endfunction

  // Write every entry so no search ever reads an unwritten one.
  // Black at 0, white at 255, and a duplicated color at 40 and 41.
  task automatic test_palette_fill();
    rgb_t twin;
    twin = random_color();
    for (int unsigned j = 0; j < ENTRIES; j++) begin
      if (j == 0) begin
        load_entry(IDX_W'(j), '0);
      end else if (j == ENTRIES - 1) begin
        load_entry(IDX_W'(j), '1);
      end else if (j == 40 || j == 41) begin
        load_entry(IDX_W'(j), twin);
      end else begin
        load_entry(IDX_W'(j), random_color());
      end
    end
  endtask

  // Reset settings: full palette, no alpha; alpha is ignored here.
  task automatic test_extremes();
    send_pixel('0, 8'h00);
    send_pixel('1, 8'hff);
    send_pixel(rgb_t'(24'h80_7f_01), 8'h00);
  endtask

  task automatic test_ties();
    configure(9'd64, 1'b0);
    send_pixel(palette_copy[40], 8'h55);
    load_entry(8'd5, rgb_t'(24'h11_22_33));
    load_entry(8'd9, rgb_t'(24'h11_22_33));
    send_pixel(rgb_t'(24'h11_22_33), 8'haa);
    // Equal distance to two neighbors.
    load_entry(8'd12, rgb_t'(24'h64_64_64));
    load_entry(8'd13, rgb_t'(24'h6e_64_64));
    send_pixel(rgb_t'(24'h69_64_64), 8'h01);
  endtask

  // Entry 0 is reserved: transparent pixels map to it, others skip it.
  task automatic test_alpha_mode();
    configure(9'd256, 1'b1);
    send_pixel(random_color(), 8'h00);
    send_pixel('0, 8'h01);
    send_pixel('1, 8'hff);
  endtask

  // Empty and one-entry ranges: an opaque pixel with no entry to search gets the empty-range index.
  task automatic test_empty_range();
    configure(9'd1, 1'b1);
    send_pixel(random_color(), 8'h80);
    send_pixel(random_color(), 8'h00);
    configure(9'd0, 1'b0);
    send_pixel(random_color(), 8'h00);
    configure(9'd1, 1'b0);
    send_pixel(random_color(), 8'hff);
  endtask

  // Counts past the palette size are clamped to it, with and without alpha mode.
  task automatic test_count_saturation();
    configure(9'd300, 1'b0);
    send_pixel('1, 8'h7f);
    configure(9'd511, 1'b1);
    send_pixel(random_color(), 8'h40);
  endtask

  // Hold off the sender until all results are back, then resume.
  task automatic test_pause();
    configure(9'd16, 1'b0);
    repeat (6) send_pixel(random_color(), CHAN_W'($urandom_range(255)));
    wait_results();
    repeat (6) send_pixel(random_color(), CHAN_W'($urandom_range(255)));
  endtask

  // Phases of random traffic, mostly small palettes, one full-palette phase.
  task automatic test_random_traffic();
    int unsigned      items;
    int unsigned      limit;
    logic [COUNT_W-1:0] count;
    logic             alpha_on;
    rgb_t             color;
    logic [CHAN_W-1:0] alpha;
    for (int phase = 0; phase < 7; phase++) begin
      count    = (phase == 0) ? 9'd1 : (phase == 2) ? 9'd256 :
                 COUNT_W'($urandom_range(2, 64));
      alpha_on = (phase == 0) ? 1'b0 : 1'($urandom_range(1));
      items    = (phase == 2) ? 60 : 90;
      configure(count, alpha_on);
      steady_flow = (phase == 4);
      limit = (count > ENTRIES) ? ENTRIES : count;
      for (int unsigned n = 0; n < items; n++) begin
        if ($urandom_range(3) == 0) begin
          load_entry(IDX_W'($urandom_range(255)), random_color());
        end else begin
          if ($urandom_range(1) == 0) begin
            color = random_color();
          end else begin
            color = palette_copy[$urandom_range(limit - 1)];
            color = '{nudge(color.red), nudge(color.green), nudge(color.blue)};
          end
          alpha = ($urandom_range(3) == 0) ? 8'd0 : CHAN_W'($urandom_range(255));
          send_pixel(color, alpha);
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = ACT_LOAD;
    m_axis_tready    = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_COLOR_COUNT;
    cfg_data_i       = '0;
    color_count_copy = COUNT_RESET;
    alpha_mode_copy  = 1'b0;
    mismatch_count   = 0;
    pixel_count      = 0;
    load_count       = 0;
    register_writes  = 0;
    result_count     = 0;
    quiet_cycles     = 0;
    steady_flow      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_palette_fill();
    test_extremes();
    test_ties();
    test_alpha_mode();
    test_empty_range();
    test_count_saturation();
    test_pause();
    test_random_traffic();

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d pixels and %0d palette loads over %0d register writes,",
             pixel_count, load_count, register_writes);
    $display("including transparent, tie, empty-range and saturated-count cases; %0d results.",
             result_count);
    if (mismatch_count == 0 && pending_indices.size() == 0) begin
      $display("tb_nearest_palette_color_top passed");
    end else begin
      $display("tb_nearest_palette_color_top failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_front.sv
rtl/npc_queue.sv
rtl/npc_back.sv
rtl/nearest_palette_color_top.sv
dv/tb_nearest_palette_color_top.sv
